### rtl/prs_pkg.sv
package prs_pkg;

  localparam int WINDOW_SLOTS = 16;
  localparam int HALF_SLOTS   = WINDOW_SLOTS / 2;
  localparam int SLOT_W       = $clog2(WINDOW_SLOTS);

  typedef struct packed {
    logic [7:0]  rx_serial;
    logic [15:0] rx_ref;
    logic [10:0] rx_len;
  } in_item_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  out_serial;
    logic [15:0] out_ref;
    logic [10:0] out_len;
    logic        out_last;
  } out_item_t;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_RESEND  = 1'b1;

  // distance classes
  typedef logic [2:0] cls_t;
  localparam cls_t CLS_INORDER = 3'd0;
  localparam cls_t CLS_NEAR    = 3'd1;
  localparam cls_t CLS_FORCE   = 3'd2;
  localparam cls_t CLS_RESYNC  = 3'd3;
  localparam cls_t CLS_OLD     = 3'd4;

  typedef logic [3:0] cmd_t;
  localparam cmd_t CMD_NOP        = 4'd0;
  localparam cmd_t CMD_LOAD       = 4'd1;
  localparam cmd_t CMD_INORDER    = 4'd2;
  localparam cmd_t CMD_STOREGAP   = 4'd3;
  localparam cmd_t CMD_FORCE_INIT = 4'd4;
  localparam cmd_t CMD_RESYNC     = 4'd5;
  localparam cmd_t CMD_FORCE_STEP = 4'd6;
  localparam cmd_t CMD_STORE      = 4'd7;
  localparam cmd_t CMD_DRAIN_STEP = 4'd8;
  localparam cmd_t CMD_DRAIN_STOP = 4'd9;
  localparam cmd_t CMD_GAP_INIT   = 4'd10;
  localparam cmd_t CMD_GAP_STEP   = 4'd11;
  localparam cmd_t CMD_FINISH     = 4'd12;

  typedef struct packed {
    logic connected;
    cls_t cls;
    logic holds_exp;
    logic force_done;
    logic drain_done;
    logic gap_end;
    logic gap_near;
  } stat_t;

endpackage

### rtl/prs_ctrl.sv
module prs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  prs_pkg::stat_t stat,
  output prs_pkg::cmd_t  cmd,
  output logic           busy
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_FORCE  = 3'd2;
  localparam logic [2:0] ST_STORE  = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_GAPCHK = 3'd5;
  localparam logic [2:0] ST_GAP    = 3'd6;
  localparam logic [2:0] ST_FIN    = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       forced_r, forced_nxt;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    forced_nxt = forced_r;
    cmd        = prs_pkg::CMD_NOP;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd       = prs_pkg::CMD_LOAD;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        forced_nxt = 1'b0;
        state_nxt  = ST_FIN;
        if (stat.connected) begin
          unique case (stat.cls)
            prs_pkg::CLS_INORDER: begin
              cmd       = prs_pkg::CMD_INORDER;
              state_nxt = ST_DRAIN;
            end
            prs_pkg::CLS_NEAR: begin
              cmd       = prs_pkg::CMD_STOREGAP;
              state_nxt = ST_GAP;
            end
            prs_pkg::CLS_FORCE: begin
              cmd        = prs_pkg::CMD_FORCE_INIT;
              forced_nxt = 1'b1;
              state_nxt  = ST_FORCE;
            end
            prs_pkg::CLS_RESYNC: cmd = prs_pkg::CMD_RESYNC;
            default: cmd = prs_pkg::CMD_NOP;
          endcase
        end
      end
      ST_FORCE: begin
        cmd = prs_pkg::CMD_FORCE_STEP;
        if (stat.force_done) state_nxt = ST_STORE;
      end
      ST_STORE: begin
        cmd       = prs_pkg::CMD_STORE;
        state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (stat.holds_exp) begin
          cmd = prs_pkg::CMD_DRAIN_STEP;
          if (stat.drain_done) state_nxt = ST_GAPCHK;
        end else begin
          cmd       = prs_pkg::CMD_DRAIN_STOP;
          state_nxt = ST_GAPCHK;
        end
      end
      ST_GAPCHK: begin
        if (forced_r && stat.gap_near) begin
          cmd       = prs_pkg::CMD_GAP_INIT;
          state_nxt = ST_GAP;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_GAP: begin
        if (stat.gap_end) state_nxt = ST_FIN;
        else cmd = prs_pkg::CMD_GAP_STEP;
      end
      ST_FIN: begin
        cmd       = prs_pkg::CMD_FINISH;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      forced_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      forced_r <= forced_nxt;
    end
  end

endmodule

### rtl/prs_dpath.sv
module prs_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  prs_pkg::in_item_t  in_item,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  prs_pkg::cmd_t      cmd,
  output prs_pkg::stat_t     stat,
  output logic               out_strobe,
  output prs_pkg::out_item_t out_item
);

  localparam int SW = prs_pkg::SLOT_W;

  prs_pkg::in_item_t  item_r;
  logic [7:0]         exp_r, q_r;
  logic [SW-1:0]      cnt_r, fm1_r;
  logic               conn_r;
  logic [prs_pkg::WINDOW_SLOTS-1:0] valid_r;
  logic [7:0]         ser_r [prs_pkg::WINDOW_SLOTS];
  logic [15:0]        ref_r [prs_pkg::WINDOW_SLOTS];
  logic [10:0]        len_r [prs_pkg::WINDOW_SLOTS];
  prs_pkg::out_item_t pend_r, out_r;
  logic               pend_v_r, out_v_r;

  logic [7:0]         ser_dist, gdist;
  logic [SW-1:0]      s_idx, e_idx, q_idx;
  logic               holds_q;
  logic               emit_v;
  prs_pkg::out_item_t emit_item;
  prs_pkg::out_item_t last_item;

  assign ser_dist = item_r.rx_serial - exp_r;
  assign gdist    = ser_dist;
  assign s_idx = item_r.rx_serial[SW-1:0];
  assign e_idx = exp_r[SW-1:0];
  assign q_idx = q_r[SW-1:0];
  assign holds_q = valid_r[q_idx] && (ser_r[q_idx] == q_r);

  always_comb begin
    stat.connected  = conn_r;
    if (ser_dist == 8'd0) stat.cls = prs_pkg::CLS_INORDER;
    else if (ser_dist < 8'(prs_pkg::HALF_SLOTS)) stat.cls = prs_pkg::CLS_NEAR;
    else if (ser_dist < 8'(prs_pkg::WINDOW_SLOTS)) stat.cls = prs_pkg::CLS_FORCE;
    else if (ser_dist < 8'(256 - prs_pkg::WINDOW_SLOTS)) stat.cls = prs_pkg::CLS_RESYNC;
    else stat.cls = prs_pkg::CLS_OLD;
    stat.holds_exp  = valid_r[e_idx] && (ser_r[e_idx] == exp_r);
    stat.force_done = (cnt_r == fm1_r);
    stat.drain_done = (cnt_r == SW'(prs_pkg::HALF_SLOTS - 1));
    stat.gap_end    = (q_r == item_r.rx_serial);
    stat.gap_near   = (gdist < 8'(prs_pkg::HALF_SLOTS));
  end

  always_comb begin
    emit_v    = 1'b0;
    emit_item = '{out_kind: prs_pkg::KIND_DELIVER, out_serial: item_r.rx_serial,
                  out_ref: item_r.rx_ref, out_len: item_r.rx_len, out_last: 1'b0};
    case (cmd)
      prs_pkg::CMD_INORDER, prs_pkg::CMD_RESYNC: emit_v = 1'b1;
      prs_pkg::CMD_FORCE_STEP, prs_pkg::CMD_DRAIN_STEP: begin
        emit_v = stat.holds_exp;
        emit_item.out_serial = exp_r;
        emit_item.out_ref    = ref_r[e_idx];
        emit_item.out_len    = len_r[e_idx];
      end
      prs_pkg::CMD_GAP_STEP: begin
        emit_v = !holds_q;
        emit_item.out_kind   = prs_pkg::KIND_RESEND;
        emit_item.out_serial = q_r;
        emit_item.out_ref    = 16'd0;
        emit_item.out_len    = 11'd0;
      end
      default: emit_v = 1'b0;
    endcase
  end

  always_comb begin
    last_item          = pend_r;
    last_item.out_last = 1'b1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_r   <= 1'b0;
      exp_r    <= 8'd0;
      valid_r  <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_we) conn_r <= cfg_wdata;
      case (cmd)
        prs_pkg::CMD_INORDER: begin
          valid_r[s_idx] <= 1'b0;
          exp_r          <= item_r.rx_serial + 8'd1;
        end
        prs_pkg::CMD_RESYNC: begin
          valid_r <= '0;
          exp_r   <= item_r.rx_serial + 8'd1;
        end
        prs_pkg::CMD_STOREGAP, prs_pkg::CMD_STORE: valid_r[s_idx] <= 1'b1;
        prs_pkg::CMD_FORCE_STEP, prs_pkg::CMD_DRAIN_STEP: begin
          valid_r[e_idx] <= 1'b0;
          exp_r          <= exp_r + 8'd1;
        end
        prs_pkg::CMD_DRAIN_STOP: valid_r[e_idx] <= 1'b0;
        default: ;
      endcase
      // one result held back so the last of an item can be marked
      if (emit_v) begin
        pend_v_r <= 1'b1;
        out_v_r  <= pend_v_r;
      end else if (cmd == prs_pkg::CMD_FINISH) begin
        pend_v_r <= 1'b0;
        out_v_r  <= pend_v_r;
      end else begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd == prs_pkg::CMD_LOAD) item_r <= in_item;
    case (cmd)
      prs_pkg::CMD_INORDER, prs_pkg::CMD_FORCE_INIT, prs_pkg::CMD_STORE: cnt_r <= '0;
      prs_pkg::CMD_FORCE_STEP, prs_pkg::CMD_DRAIN_STEP: cnt_r <= cnt_r + SW'(1);
      default: ;
    endcase
    if (cmd == prs_pkg::CMD_FORCE_INIT) fm1_r <= SW'(ser_dist - 8'(prs_pkg::HALF_SLOTS));
    if (cmd == prs_pkg::CMD_STOREGAP || cmd == prs_pkg::CMD_GAP_INIT) q_r <= exp_r;
    else if (cmd == prs_pkg::CMD_GAP_STEP) q_r <= q_r + 8'd1;
    if (cmd == prs_pkg::CMD_STOREGAP || cmd == prs_pkg::CMD_STORE) begin
      ser_r[s_idx] <= item_r.rx_serial;
      ref_r[s_idx] <= item_r.rx_ref;
      len_r[s_idx] <= item_r.rx_len;
    end
    if (emit_v) begin
      pend_r <= emit_item;
      out_r  <= pend_r;
    end else if (cmd == prs_pkg::CMD_FINISH) begin
      out_r <= last_item;
    end
  end

  assign out_strobe = out_v_r;
  assign out_item   = out_r;

endmodule

### rtl/packet_resequencer_with_nack.sv
// Receive-side resequencer for packets with 8-bit serial numbers.
// Pulse start with a packet descriptor on in_item while busy is low; the
// item is taken at that edge and busy stays high until the last of its
// results is registered. Results appear on out_item, one per cycle at most,
// each marked by out_strobe for exactly one cycle; out_last is set on the final
// result of an item. A deliver carries the packet handle and length, a
// resend request carries the missing serial with zero handle and length.
// Busy covers decide, then as the serial distance calls for them a forced
// advance of up to 8 slots, the store, the drain, the gap check and the gap
// walk, and last the finish. One window slot is visited per cycle by the
// sequencer. The next item is taken at the edge after busy falls; start is
// ignored while busy is high, so no item is taken before the last one is
// through. The last result is on out_item in the first cycle with busy low.
// cfg_we/cfg_wdata set the connected flag; while it is clear, items are
// taken and dropped. Write it only while busy is low.
// Reset empties the window, expects serial 0 and leaves the channel
// disconnected. The receiver cannot hold results off, so none is stalled.
module packet_resequencer_with_nack (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  prs_pkg::in_item_t  in_item,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  output logic               out_strobe,
  output prs_pkg::out_item_t out_item
);

  prs_pkg::cmd_t  cmd;
  prs_pkg::stat_t stat;

  prs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  prs_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  a_result_in_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result outside an item");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.out_last) |=> !out_strobe)
    else $error("result after last");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.out_last) |-> !busy)
    else $error("busy after last result");

endmodule

### tb/sv/packet_resequencer_with_nack_tb.sv
module packet_resequencer_with_nack_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  prs_pkg::in_item_t in_item = '0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic out_strobe;
  prs_pkg::out_item_t out_item;

  packet_resequencer_with_nack u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .out_strobe(out_strobe),
    .out_item(out_item)
  );

  always #6 clk = ~clk;

  // shadow of the window
  logic               link_up;
  logic [7:0]         next_serial;
  logic               win_valid [prs_pkg::WINDOW_SLOTS];
  logic [7:0]         win_serial [prs_pkg::WINDOW_SLOTS];
  logic [15:0]        win_ref [prs_pkg::WINDOW_SLOTS];
  logic [10:0]        win_len [prs_pkg::WINDOW_SLOTS];
  prs_pkg::out_item_t pending_results [$];
  prs_pkg::out_item_t item_results [$];

  int errors = 0;
  int items_sent = 0;
  int delivers_seen = 0;
  int resends_seen = 0;

  function automatic bit slot_holds(logic [7:0] s);
    return win_valid[s % prs_pkg::WINDOW_SLOTS] &&
           win_serial[s % prs_pkg::WINDOW_SLOTS] == s;
  endfunction

  function automatic void add_result(logic k, logic [7:0] s, logic [15:0] r,
                                     logic [10:0] l);
    prs_pkg::out_item_t o;
    o.out_kind = k; o.out_serial = s; o.out_ref = r; o.out_len = l;
    o.out_last = 1'b0;
    item_results.push_back(o);
  endfunction

  function automatic void deliver_held(logic [7:0] s);
    int i;
    i = s % prs_pkg::WINDOW_SLOTS;
    add_result(prs_pkg::KIND_DELIVER, s, win_ref[i], win_len[i]);
    win_valid[i] = 1'b0;
  endfunction

  function automatic void drain_window();
    for (int k = 0; k < prs_pkg::HALF_SLOTS; k++) begin
      if (slot_holds(next_serial)) begin
        deliver_held(next_serial);
        next_serial = next_serial + 8'd1;
      end else begin
        win_valid[next_serial % prs_pkg::WINDOW_SLOTS] = 1'b0;
        break;
      end
    end
  endfunction

  function automatic void request_missing(logic [7:0] s);
    logic [7:0] q;
    q = next_serial;
    while (q != s) begin
      if (!slot_holds(q)) add_result(prs_pkg::KIND_RESEND, q, 16'd0, 11'd0);
      q = q + 8'd1;
    end
  endfunction

  function automatic void hold_packet(prs_pkg::in_item_t it);
    int i;
    i = it.rx_serial % prs_pkg::WINDOW_SLOTS;
    win_valid[i] = 1'b1;
    win_serial[i] = it.rx_serial;
    win_ref[i] = it.rx_ref;
    win_len[i] = it.rx_len;
  endfunction

  function automatic void resequence(prs_pkg::in_item_t it);
    logic [7:0] ser_dist;
    int adv;
    item_results.delete();
    if (!link_up) return;
    ser_dist = it.rx_serial - next_serial;
    if (ser_dist == 0) begin
      add_result(prs_pkg::KIND_DELIVER, it.rx_serial, it.rx_ref, it.rx_len);
      win_valid[it.rx_serial % prs_pkg::WINDOW_SLOTS] = 1'b0;
      next_serial = it.rx_serial + 8'd1;
      drain_window();
    end else if (ser_dist < prs_pkg::HALF_SLOTS) begin
      hold_packet(it);
      request_missing(it.rx_serial);
    end else if (ser_dist < prs_pkg::WINDOW_SLOTS) begin
      adv = ser_dist - prs_pkg::HALF_SLOTS + 1;
      for (int k = 0; k < adv; k++) begin
        if (slot_holds(next_serial)) deliver_held(next_serial);
        win_valid[next_serial % prs_pkg::WINDOW_SLOTS] = 1'b0;
        next_serial = next_serial + 8'd1;
      end
      hold_packet(it);
      drain_window();
      if (8'(it.rx_serial - next_serial) < prs_pkg::HALF_SLOTS)
        request_missing(it.rx_serial);
    end else if (ser_dist < 256 - prs_pkg::WINDOW_SLOTS) begin
      for (int i = 0; i < prs_pkg::WINDOW_SLOTS; i++) win_valid[i] = 1'b0;
      add_result(prs_pkg::KIND_DELIVER, it.rx_serial, it.rx_ref, it.rx_len);
      next_serial = it.rx_serial + 8'd1;
    end
    if (item_results.size() > 0) item_results[$].out_last = 1'b1;
    foreach (item_results[i]) pending_results.push_back(item_results[i]);
  endfunction

  // result checker
  always @(posedge clk) begin
    prs_pkg::out_item_t want;
    if (rst_n && out_strobe) begin
      if (out_item.out_kind == prs_pkg::KIND_DELIVER) delivers_seen++;
      else resends_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", out_item);
      end else begin
        want = pending_results.pop_front();
        if (out_item.out_kind !== want.out_kind || out_item.out_serial !== want.out_serial ||
            out_item.out_ref !== want.out_ref || out_item.out_len !== want.out_len ||
            out_item.out_last !== want.out_last) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", want, out_item);
        end
      end
    end
  end

  task automatic send_packet(logic [7:0] s, logic [15:0] r, logic [10:0] l);
    @(negedge clk);
    start = 1'b1;
    in_item = '{rx_serial: s, rx_ref: r, rx_len: l};
    do @(posedge clk); while (busy);
    resequence(in_item);
    items_sent++;
  endtask

  task automatic pause(int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // let the block run dry; items without results may still be in flight
  task automatic settle();
    int guard;
    pause(0);
    guard = 0;
    while (pending_results.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_link(logic v);
    settle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    link_up = v;
  endtask

  task automatic test_disconnected();
    send_packet(8'd0, 16'h1234, 11'd10);
    send_packet(8'd5, 16'hFFFF, 11'd2047);
    send_packet(8'd200, 16'h0000, 11'd1);
    write_link(1'b1);
  endtask

  task automatic test_directed();
    send_packet(8'd0, 16'hFFFF, 11'd2047);    // in order, extremes
    send_packet(8'd1, 16'h0000, 11'd0);       // length zero
    send_packet(8'd5, 16'hA5A5, 11'd100);     // gap, resends
    send_packet(8'd5, 16'h5A5A, 11'd101);     // duplicate overwritten
    send_packet(8'd3, 16'h0003, 11'd3);
    send_packet(8'd2, 16'h0002, 11'd2);       // drains 3, stops at 4
    send_packet(8'd4, 16'h0004, 11'd4);       // delivers 4, then the held 5
    send_packet(8'd9, 16'h0009, 11'd9);
    send_packet(8'd21, 16'h0015, 11'd21);     // forced advance, largest distance
    send_packet(8'd14, 16'h000E, 11'd14);
    send_packet(8'd23, 16'h0017, 11'd23);     // forced advance, smallest; 21 held
    send_packet(8'd100, 16'h0064, 11'd64);    // resync
    send_packet(8'd100, 16'h0064, 11'd64);    // old
    send_packet(8'd85, 16'h0055, 11'd1);      // old, far edge
    send_packet(8'd117, 16'h0075, 11'd7);     // resync, nearest
    send_packet(8'd103, 16'h0067, 11'd5);     // old
    send_packet(8'd119, 16'h0077, 11'd9);     // gap of one
    send_packet(8'd255, 16'h00FF, 11'd1023);  // resync to top serial
    send_packet(8'd0, 16'h8000, 11'd1024);    // wrap
    send_packet(8'd255, 16'h7FFF, 11'd512);
  endtask

  task automatic test_random(int n);
    int burst;
    int pick;
    logic [7:0] s;
    burst = $urandom_range(1, 12);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) s = next_serial + 8'($urandom_range(0, 7));
      else if (pick < 78) s = next_serial + 8'($urandom_range(8, 15));
      else if (pick < 88) s = next_serial + 8'($urandom_range(16, 239));
      else s = next_serial + 8'($urandom_range(240, 255));
      send_packet(s, 16'($urandom), 11'($urandom_range(0, 2047)));
      if (--burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 20));
      end
    end
  endtask

  task automatic test_reconnect();
    write_link(1'b0);
    test_random(10);
    write_link(1'b1);
  endtask

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    link_up = 1'b0;
    next_serial = '0;
    for (int i = 0; i < prs_pkg::WINDOW_SLOTS; i++) begin
      win_valid[i] = 1'b0; win_serial[i] = '0; win_ref[i] = '0; win_len[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_disconnected();
    test_directed();
    test_random(100);
    test_reconnect();
    test_random(110);
    settle();
    errors += pending_results.size();
    $display("%0d items sent, %0d deliveries and %0d resend requests checked",
             items_sent, delivers_seen, resends_seen);
    $display("covered: disconnected link, in-order, gaps, forced advance, resync, old");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
